// ----- design/lrd3d_pkg.sv -----
// shared constants and helpers for the recursive table-driven denoiser
// no dependencies; imported by the output queue and the top level
package lrd3d_pkg;

    localparam int PIX_W         = 8;
    localparam int COEF_W        = 9;
    localparam int TSEL_W        = 2;
    localparam int DIFF_W        = 9;
    localparam int DIFF_BIAS     = 256;
    localparam int COEF_DEPTH    = 2048;
    localparam int COEF_AW       = TSEL_W + DIFF_W;
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int OUT_Q_DEPTH   = 4;

    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // low bit of a table select picks spatial or temporal within a plane
    localparam logic TBL_SPATIAL  = 1'b0;
    localparam logic TBL_TEMPORAL = 1'b1;

    // table entry for difference p - c, biased into the 9-bit row index
    function automatic logic [COEF_AW-1:0] coef_addr(
        input logic [TSEL_W-1:0] sel,
        input logic [PIX_W-1:0]  p,
        input logic [PIX_W-1:0]  c
    );
        logic [DIFF_W-1:0] idx;
        idx = DIFF_W'({1'b0, p}) - DIFF_W'({1'b0, c}) + DIFF_W'(DIFF_BIAS);
        return {sel, idx};
    endfunction

    // c plus signed correction, wrapped to 8 bits
    function automatic logic [PIX_W-1:0] lp_add(
        input logic [PIX_W-1:0]  c,
        input logic [COEF_W-1:0] corr
    );
        return c + corr[PIX_W-1:0];
    endfunction

endpackage

// ----- design/lrd3d_ram.sv -----
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
module lrd3d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/lrd3d_out_queue.sv -----
// small result queue between the filter pipeline and the output port
// depends on lrd3d_pkg
module lrd3d_out_queue #(
    parameter int DEPTH = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic [lrd3d_pkg::PIX_W-1:0] push_data,
    input  logic                      pop,
    output logic                      not_empty,
    output logic [lrd3d_pkg::PIX_W-1:0] head
);
    import lrd3d_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [PIX_W-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

endmodule

// ----- design/recursive_lut_denoise_3d_core.sv -----
// top level of the recursive table-driven spatio-temporal denoiser
// depends on lrd3d_pkg, lrd3d_ram and lrd3d_out_queue
//
// A filter word passes stages h1, v0, v1 and t1: the running horizontal value
// recurs through a synchronous coefficient ram read and an add, so filter words
// are taken only on slots where the phase register is low, and only while the
// output queue has credit left; each result then enters the output queue, with
// out_valid high. A load word waits until no filter word is still due to read
// the tables. After reset a clearing pass over all 2048 entries zeroes the
// coefficient tables, during which no word is taken. The line store is not
// cleared: a pixel below the top row must follow a row that wrote its column.
// Two copies of the coefficient store give two read ports; both are written by
// every load and by the clear.
module recursive_lut_denoise_3d_core #(
    parameter int MAX_WIDTH = lrd3d_pkg::MAX_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                cmd,
    input  logic                                plane_is_chroma,
    input  logic                                first_row,
    input  logic                                first_col,
    input  logic [lrd3d_pkg::PIX_W-1:0]         pixel_cur,
    input  logic [lrd3d_pkg::PIX_W-1:0]         pixel_prev,
    input  logic [lrd3d_pkg::TSEL_W-1:0]        table_select,
    input  logic signed [lrd3d_pkg::DIFF_W-1:0] table_offset,
    input  logic signed [lrd3d_pkg::COEF_W-1:0] table_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lrd3d_pkg::PIX_W-1:0]         filtered_pixel
);
    import lrd3d_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int PEND_W = $clog2(OUT_Q_DEPTH + 1);

    // ---------------- control: clearing pass, slot phase, credit ----------------
    logic               clr_active_reg;
    logic [COEF_AW-1:0] clr_addr_reg;
    logic               phase_reg;      // pixels enter only when low
    logic [PEND_W-1:0]  pending_reg;    // words in flight plus queued results
    logic [PEND_W-1:0]  pending_next;

    logic pix_ok;
    logic load_ok;
    logic pix_acc;
    logic load_acc;
    logic out_acc;

    // ---------------- pipeline registers ----------------
    // h1: horizontal coefficient and line word arrive
    logic             s1_valid_reg;
    logic             s1_first_col_reg;
    logic             s1_first_row_reg;
    logic             s1_chroma_reg;
    logic [PIX_W-1:0] s1_cur_reg;
    logic [PIX_W-1:0] s1_prev_reg;
    logic [COL_W-1:0] s1_col_reg;
    // v0: vertical coefficient read issued
    logic             s2_valid_reg;
    logic             s2_first_row_reg;
    logic             s2_chroma_reg;
    logic [PIX_W-1:0] s2_prev_reg;
    logic [COL_W-1:0] s2_col_reg;
    logic [PIX_W-1:0] s2_rp_reg;
    logic [PIX_W-1:0] s2_line_reg;
    // v1: vertical result, line write, temporal read issued
    logic             s3_valid_reg;
    logic             s3_first_row_reg;
    logic             s3_chroma_reg;
    logic [PIX_W-1:0] s3_prev_reg;
    logic [COL_W-1:0] s3_col_reg;
    logic [PIX_W-1:0] s3_rp_reg;
    // t1: temporal coefficient arrives, result formed
    logic             s4_valid_reg;
    logic [PIX_W-1:0] s4_vres_reg;

    // running horizontal value and column position
    logic [PIX_W-1:0] rp_reg;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;

    // ---------------- ram hookup ----------------
    logic               coef_we;
    logic [COEF_AW-1:0] coef_waddr;
    logic [COEF_W-1:0]  coef_wdata;
    logic [COEF_AW-1:0] coef_a_raddr;
    logic [COEF_AW-1:0] coef_b_raddr;
    logic [COEF_W-1:0]  coef_a_rdata;
    logic [COEF_W-1:0]  coef_b_rdata;
    logic [PIX_W-1:0]   line_rdata;

    logic [PIX_W-1:0] rp_new;
    logic [PIX_W-1:0] line_fwd;
    logic [PIX_W-1:0] vres;
    logic [PIX_W-1:0] result;

    logic             q_not_empty;
    logic [PIX_W-1:0] q_head;

    // ---------------- handshake ----------------
    // loads must not overtake a pixel that still reads the tables
    assign load_ok  = !s1_valid_reg && !s2_valid_reg && !s3_valid_reg;
    assign pix_ok   = !phase_reg && (pending_reg < PEND_W'(OUT_Q_DEPTH));
    assign in_ready = !clr_active_reg && ((cmd == CMD_LOAD) ? load_ok : pix_ok);
    assign pix_acc  = in_valid && in_ready && (cmd == CMD_FILTER);
    assign load_acc = in_valid && in_ready && (cmd == CMD_LOAD);
    assign out_acc  = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (pix_acc && !out_acc)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (out_acc && !pix_acc)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    // column restarts on first_col and wraps at the line store depth
    always_comb
    begin
        if (first_col || (col_reg == COL_W'(MAX_WIDTH - 1)))
        begin
            col_next = '0;
        end
        else
        begin
            col_next = col_reg + 1'b1;
        end
    end

    // ---------------- coefficient store write: clear or load ----------------
    always_comb
    begin
        if (clr_active_reg)
        begin
            coef_we    = 1'b1;
            coef_waddr = clr_addr_reg;
            coef_wdata = '0;
        end
        else
        begin
            coef_we    = load_acc;
            coef_waddr = {table_select,
                          DIFF_W'(table_offset) + DIFF_W'(DIFF_BIAS)};
            coef_wdata = COEF_W'(table_value);
        end
    end

    // ---------------- datapath ----------------
    // h1: new running value, line word with forwarding from the write in v1
    assign rp_new   = s1_first_col_reg ? s1_cur_reg : lp_add(s1_cur_reg, coef_a_rdata);
    assign line_fwd = (s3_valid_reg && (s3_col_reg == s1_col_reg)) ? vres : line_rdata;

    // v0: vertical table read
    assign coef_b_raddr = coef_addr({s2_chroma_reg, TBL_SPATIAL}, s2_line_reg, s2_rp_reg);

    // v1: vertical result
    assign vres = s3_first_row_reg ? s3_rp_reg : lp_add(s3_rp_reg, coef_b_rdata);

    // port a: horizontal read on the entry slot, temporal read on the odd slot
    always_comb
    begin
        if (s3_valid_reg)
        begin
            coef_a_raddr = coef_addr({s3_chroma_reg, TBL_TEMPORAL}, s3_prev_reg, vres);
        end
        else
        begin
            coef_a_raddr = coef_addr({plane_is_chroma, TBL_SPATIAL}, rp_reg, pixel_cur);
        end
    end

    // t1: temporal result
    assign result = lp_add(s4_vres_reg, coef_a_rdata);

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            phase_reg      <= 1'b0;
            pending_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            rp_reg         <= '0;
            col_reg        <= '0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == COEF_AW'(COEF_DEPTH - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            phase_reg    <= !phase_reg;
            pending_reg  <= pending_next;
            s1_valid_reg <= pix_acc;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            if (pix_acc)
            begin
                col_reg <= col_next;
            end
            if (s1_valid_reg)
            begin
                rp_reg <= rp_new;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            s1_first_col_reg <= first_col;
            s1_first_row_reg <= first_row;
            s1_chroma_reg    <= plane_is_chroma;
            s1_cur_reg       <= pixel_cur;
            s1_prev_reg      <= pixel_prev;
            s1_col_reg       <= col_next;
        end
        s2_first_row_reg <= s1_first_row_reg;
        s2_chroma_reg    <= s1_chroma_reg;
        s2_prev_reg      <= s1_prev_reg;
        s2_col_reg       <= s1_col_reg;
        s2_rp_reg        <= rp_new;
        s2_line_reg      <= line_fwd;
        s3_first_row_reg <= s2_first_row_reg;
        s3_chroma_reg    <= s2_chroma_reg;
        s3_prev_reg      <= s2_prev_reg;
        s3_col_reg       <= s2_col_reg;
        s3_rp_reg        <= s2_rp_reg;
        s4_vres_reg      <= vres;
    end

    // ---------------- memories ----------------
    // copy a: horizontal and temporal lookups
    lrd3d_ram #(
        .WIDTH (COEF_W),
        .DEPTH (COEF_DEPTH)
    ) u_coef_a (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .re    (1'b1),
        .raddr (coef_a_raddr),
        .rdata (coef_a_rdata)
    );

    // copy b: vertical lookup
    lrd3d_ram #(
        .WIDTH (COEF_W),
        .DEPTH (COEF_DEPTH)
    ) u_coef_b (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .re    (1'b1),
        .raddr (coef_b_raddr),
        .rdata (coef_b_rdata)
    );

    // previous row's vertical results, read on entry, written back in v1
    lrd3d_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .clk   (clk),
        .we    (s3_valid_reg),
        .waddr (s3_col_reg),
        .wdata (vres),
        .re    (pix_acc),
        .raddr (col_next),
        .rdata (line_rdata)
    );

    // ---------------- output ----------------
    lrd3d_out_queue #(
        .DEPTH (OUT_Q_DEPTH)
    ) u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s4_valid_reg),
        .push_data (result),
        .pop       (out_acc),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    assign out_valid      = q_not_empty;
    assign filtered_pixel = q_head;

endmodule
